/* sv/smc_pkg.sv */
package smc_pkg;

  // Transaction kind held while the bus is busy.
  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Request codes carried by the action field.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Waveform segments of a transaction.
  typedef enum logic [2:0] {
    SEG_START    = 3'd0,
    SEG_STOP     = 3'd1,
    SEG_SEND_WA  = 3'd2,
    SEG_SEND_REG = 3'd3,
    SEG_SEND_DAT = 3'd4,
    SEG_SEND_RA  = 3'd5,
    SEG_RECV     = 3'd6
  } seg_t;

  // Sub-tick phases of one bit: data set, clock high, clock low.
  localparam logic [1:0] SUB_SETUP = 2'd0;
  localparam logic [1:0] SUB_HIGH  = 2'd1;
  localparam logic [1:0] SUB_LOW   = 2'd2;

  // Eight data bits, then the ninth (acknowledge) bit at this index.
  localparam logic [3:0] ACK_BIT = 4'd8;
  localparam int unsigned BYTE_MSB = 7;

  // Segments in each transaction.
  localparam logic [3:0] WRITE_SEGS = 4'd5;
  localparam logic [3:0] READ_SEGS  = 4'd8;

  // Configuration register indexes.
  localparam logic [0:0] CFG_WRITE_ADDR = 1'b0;
  localparam logic [0:0] CFG_READ_ADDR  = 1'b1;

  // One request word.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       data_line_in;
  } smc_item_t;

  // One result word.
  typedef struct packed {
    logic       clock_line;
    logic       data_line_out;
    logic       data_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } smc_result_t;

  // Segment sequence of each transaction kind.
  function automatic seg_t plan_seg(op_t kind, logic [3:0] idx);
    seg_t seg;
    seg = SEG_START;
    if (kind == OP_READ) begin
      case (idx)
        4'd0:    seg = SEG_START;
        4'd1:    seg = SEG_SEND_WA;
        4'd2:    seg = SEG_SEND_REG;
        4'd3:    seg = SEG_STOP;
        4'd4:    seg = SEG_START;
        4'd5:    seg = SEG_SEND_RA;
        4'd6:    seg = SEG_RECV;
        4'd7:    seg = SEG_STOP;
        default: seg = SEG_START;
      endcase
    end else begin
      case (idx)
        4'd0:    seg = SEG_START;
        4'd1:    seg = SEG_SEND_WA;
        4'd2:    seg = SEG_SEND_REG;
        4'd3:    seg = SEG_SEND_DAT;
        4'd4:    seg = SEG_STOP;
        default: seg = SEG_START;
      endcase
    end
    return seg;
  endfunction

endpackage

/* sv/smc_seq.sv */
module smc_seq
  import smc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step_en,
  input  smc_item_t   item,
  input  logic [7:0]  write_address,
  input  logic [7:0]  read_address,
  output smc_result_t result
);

  op_t        op_kind;
  op_t        op_kind_next;
  logic [3:0] seg_index;
  logic [3:0] seg_index_next;
  logic [3:0] bit_index;
  logic [3:0] bit_index_next;
  logic [1:0] sub_tick;
  logic [1:0] sub_tick_next;
  logic [7:0] shift_reg;
  logic [7:0] shift_reg_next;
  logic [7:0] received_byte;
  logic [7:0] received_byte_next;
  logic       pin_clk;
  logic       pin_clk_next;
  logic       pin_dat;
  logic       pin_dat_next;
  logic       pin_oe;
  logic       pin_oe_next;
  logic [7:0] held_register;
  logic [7:0] held_register_next;
  logic [7:0] held_data;
  logic [7:0] held_data_next;

  logic       active;
  logic       start_req;
  op_t        kind_e;
  logic [3:0] seg_e;
  logic [3:0] bit_e;
  logic [1:0] sub_e;
  seg_t       seg;
  logic [7:0] sr_cur;
  logic       last_tick;
  logic [3:0] seg_inc;
  logic [3:0] seg_count;
  logic       busy;
  logic       done;

  // One waveform step: decode the current segment and advance the counters.
  always_comb begin
    active    = (op_kind == OP_WRITE) || (op_kind == OP_READ);
    start_req = !active && ((item.action == ACT_WRITE) || (item.action == ACT_READ));

    held_register_next = start_req ? item.register_address : held_register;
    held_data_next     = start_req ? item.write_data : held_data;

    kind_e = start_req ? op_t'(item.action) : (active ? op_kind : OP_IDLE);
    seg_e  = start_req ? 4'd0 : seg_index;
    bit_e  = start_req ? 4'd0 : bit_index;
    sub_e  = start_req ? SUB_SETUP : sub_tick;

    seg       = plan_seg(kind_e, seg_e);
    seg_count = (kind_e == OP_WRITE) ? WRITE_SEGS : READ_SEGS;
    seg_inc   = seg_e + 4'd1;

    op_kind_next       = kind_e;
    seg_index_next     = seg_e;
    bit_index_next     = bit_e;
    sub_tick_next      = sub_e;
    shift_reg_next     = shift_reg;
    received_byte_next = received_byte;
    pin_clk_next       = pin_clk;
    pin_dat_next       = pin_dat;
    pin_oe_next        = pin_oe;
    sr_cur             = shift_reg;
    last_tick          = 1'b0;
    busy               = 1'b0;
    done               = 1'b0;

    if (kind_e != OP_IDLE) begin
      busy = 1'b1;
      unique case (seg)
        SEG_START: begin
          pin_clk_next = (sub_e != SUB_LOW);
          pin_dat_next = (sub_e == SUB_SETUP);
          pin_oe_next  = 1'b1;
          last_tick    = (sub_e == SUB_LOW);
        end
        SEG_STOP: begin
          pin_clk_next = (sub_e != SUB_SETUP);
          pin_dat_next = (sub_e == SUB_LOW);
          pin_oe_next  = 1'b1;
          last_tick    = (sub_e == SUB_LOW);
        end
        SEG_RECV: begin
          pin_clk_next = (sub_e == SUB_HIGH);
          if (bit_e < ACK_BIT) begin
            // Released line: sample on the clock-high tick.
            pin_oe_next = 1'b0;
            if (sub_e == SUB_HIGH) begin
              shift_reg_next = {shift_reg[BYTE_MSB-1:0], item.data_line_in};
            end
          end else begin
            // Driven-high not-acknowledge.
            pin_dat_next = 1'b1;
            pin_oe_next  = 1'b1;
          end
          last_tick = (bit_e == ACK_BIT) && (sub_e == SUB_LOW);
          if (last_tick) begin
            received_byte_next = shift_reg;
          end
        end
        SEG_SEND_WA, SEG_SEND_REG, SEG_SEND_DAT, SEG_SEND_RA: begin
          // Load the byte at the first tick of the segment.
          if ((bit_e == 4'd0) && (sub_e == SUB_SETUP)) begin
            case (seg)
              SEG_SEND_WA:  sr_cur = write_address;
              SEG_SEND_REG: sr_cur = held_register_next;
              SEG_SEND_DAT: sr_cur = held_data_next;
              default:      sr_cur = read_address;
            endcase
          end
          shift_reg_next = sr_cur;
          pin_clk_next   = (sub_e == SUB_HIGH);
          if (bit_e < ACK_BIT) begin
            pin_dat_next = sr_cur[BYTE_MSB];
            pin_oe_next  = 1'b1;
            if (sub_e == SUB_LOW) begin
              shift_reg_next = {sr_cur[BYTE_MSB-1:0], 1'b0};
            end
          end else begin
            // Released ninth bit, acknowledge ignored.
            pin_oe_next = 1'b0;
          end
          last_tick = (bit_e == ACK_BIT) && (sub_e == SUB_LOW);
        end
        default: begin
          last_tick = 1'b0;
        end
      endcase

      // Counter advance.
      if (sub_e != SUB_LOW) begin
        sub_tick_next = sub_e + 2'd1;
      end else begin
        sub_tick_next  = SUB_SETUP;
        bit_index_next = bit_e + 4'd1;
      end
      if (last_tick) begin
        sub_tick_next  = SUB_SETUP;
        bit_index_next = 4'd0;
        seg_index_next = seg_inc;
        if (seg_inc >= seg_count) begin
          op_kind_next   = OP_IDLE;
          seg_index_next = 4'd0;
          done           = 1'b1;
        end
      end
    end

    result.clock_line        = pin_clk_next;
    result.data_line_out     = pin_dat_next;
    result.data_drive_enable = pin_oe_next;
    result.busy_res          = busy;
    result.done_res          = done;
    result.read_data         = received_byte_next;
  end

  // Sequencer state, advanced once per word.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_kind       <= OP_IDLE;
      seg_index     <= 4'd0;
      bit_index     <= 4'd0;
      sub_tick      <= SUB_SETUP;
      shift_reg     <= 8'd0;
      received_byte <= 8'd0;
      pin_clk       <= 1'b1;
      pin_dat       <= 1'b1;
      pin_oe        <= 1'b1;
    end else if (step_en) begin
      op_kind       <= op_kind_next;
      seg_index     <= seg_index_next;
      bit_index     <= bit_index_next;
      sub_tick      <= sub_tick_next;
      shift_reg     <= shift_reg_next;
      received_byte <= received_byte_next;
      pin_clk       <= pin_clk_next;
      pin_dat       <= pin_dat_next;
      pin_oe        <= pin_oe_next;
    end
  end

  // Request bytes latched at the start of a transaction.
  always_ff @(posedge clk) begin
    if (step_en) begin
      held_register <= held_register_next;
      held_data     <= held_data_next;
    end
  end

endmodule

/* sv/sccb_master_controller_unit.sv */
// SCCB master clocked by its input stream: every accepted word is one bus
// delay tick and gives exactly one result word with the pin levels of that
// tick. A word with action write or read starts a transaction when the bus is
// idle and is ignored otherwise; bytes go out MSB first in three ticks per bit
// with an unchecked ninth bit. The block takes one word per cycle unless a
// full result register waits on m_tready; each word passes the input
// register, then the sequencer step into the result register. The user must
// write the two device address registers through the cfg port only while no
// transaction is running; the block itself does not enforce this.
module sccb_master_controller_unit
  import smc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Request words.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // [7:0] register_address, [15:8] write_data,
                                // [16] data_line_in, [23:17] zero
  input  logic [1:0]  s_tuser,  // [1:0] action
  // Result words.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [0] clock_line, [1] data_line_out,
                                // [2] data_drive_enable, [3] busy_res,
                                // [4] done_res, [12:5] read_data, [15:13] zero
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic        in_valid;
  smc_item_t   in_item;
  logic        out_valid;
  smc_result_t out_res;
  smc_result_t step_res;
  logic        advance;
  logic [7:0]  write_address;
  logic [7:0]  read_address;

  // Stage handshake: the step fires when the result register can take it.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_res.read_data, out_res.done_res, out_res.busy_res,
                     out_res.data_drive_enable, out_res.data_line_out,
                     out_res.clock_line};
  assign cfg_ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action           <= s_tuser;
      in_item.register_address <= s_tdata[7:0];
      in_item.write_data       <= s_tdata[15:8];
      in_item.data_line_in     <= s_tdata[16];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  // Device address registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_address <= 8'd66;
      read_address  <= 8'd67;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WRITE_ADDR: write_address <= cfg_data;
        CFG_READ_ADDR:  read_address  <= cfg_data;
        default:        write_address <= write_address;
      endcase
    end
  end

  smc_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .step_en       (advance),
    .item          (in_item),
    .write_address (write_address),
    .read_address  (read_address),
    .result        (step_res)
  );

endmodule
